// ===== rtl/core/mqtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mqtd_pkg
// Shared codes and types for the multi-queue ticket dispenser.
// ----------------------------------------------------------------------------
package mqtd_pkg;

  localparam int MAP_FIELD_BITS = 4;
  localparam int MAX_SLOTS      = 16;

  localparam logic [1:0] CMD_PUSH      = 2'd0;
  localparam logic [1:0] CMD_NEXT      = 2'd1;
  localparam logic [1:0] CMD_QRY_CNT   = 2'd2;
  localparam logic [1:0] CMD_QRY_QUEUE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REG_MAP = 1'b0;

  typedef struct packed {
    logic       valid;
    logic [1:0] command;
    logic [3:0] id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ticket;
    logic [3:0]  selected_queue;
    logic [15:0] queue_head;
    logic [15:0] tickets_waiting;
    logic [4:0]  counters_on_queue;
    logic [4:0]  first_idle_counter;
  } rsp_t;

endpackage

// ===== rtl/core/mqtd_cfg.sv =====
// ----------------------------------------------------------------------------
// mqtd_cfg
// APB register port holding the counter-to-queue map.
// ----------------------------------------------------------------------------
module mqtd_cfg
  import mqtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic [63:0] map
);

  logic map_hit;

  // registers sit on 8-byte steps, low address bits ignored
  assign map_hit = (paddr[3] == REG_MAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      map <= '0;
    end else if (psel && penable && pwrite && map_hit) begin
      map <= pwdata;
    end
  end

  assign prdata = map_hit ? map : '0;

endmodule

// ===== rtl/core/mqtd_exec.sv =====
// ----------------------------------------------------------------------------
// mqtd_exec
// Queue head/tail files, served flags, single-pass command logic and the
// result register.
// ----------------------------------------------------------------------------
module mqtd_exec
  import mqtd_pkg::*;
#(
  parameter int NUM_SLOTS   = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic [63:0] map,
  output logic        done,
  output rsp_t        rsp
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [4:0] NS5 = 5'(NUM_SLOTS);
  localparam logic [TICKET_BITS-1:0] TMAX = {TICKET_BITS{1'b1}};

  logic [TICKET_BITS-1:0] heads [NUM_SLOTS];
  logic [TICKET_BITS-1:0] tails [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   served;

  logic [3:0]             queue;
  logic                   slot_ok;
  logic [SW-1:0]          q_idx;
  logic [SW-1:0]          c_idx;
  logic [TICKET_BITS-1:0] head_cur;
  logic [TICKET_BITS-1:0] tail_cur;
  logic                   is_push;
  logic                   is_next;
  logic                   full;
  logic                   empty;
  logic                   push_ok;
  logic                   next_ok;
  logic [TICKET_BITS-1:0] head_new;
  logic [TICKET_BITS-1:0] tail_new;
  logic [TICKET_BITS-1:0] tkt;
  logic [TICKET_BITS-1:0] waiting;
  logic [NUM_SLOTS-1:0]   served_next;
  logic [4:0]             count;
  logic [4:0]             first_idle;
  rsp_t                   rsp_next;

  always_comb begin
    if (req.command == CMD_NEXT || req.command == CMD_QRY_CNT) begin
      queue = map[{req.id, 2'b00} +: MAP_FIELD_BITS];
    end else begin
      queue = req.id;
    end
    slot_ok = ({1'b0, queue} < NS5) && ({1'b0, req.id} < NS5);
    q_idx = queue[SW-1:0];
    c_idx = req.id[SW-1:0];
    head_cur = heads[q_idx];
    tail_cur = tails[q_idx];

    is_push = slot_ok && (req.command == CMD_PUSH);
    is_next = slot_ok && (req.command == CMD_NEXT);
    full = (tail_cur == TMAX);
    empty = !(head_cur < tail_cur);
    push_ok = is_push && !full;
    next_ok = is_next && !empty;

    tail_new = push_ok ? tail_cur + 1'b1 : tail_cur;
    head_new = next_ok ? head_cur + 1'b1 : head_cur;
    waiting = tail_new - head_new;

    if (push_ok) begin
      tkt = tail_new;
    end else if (next_ok) begin
      tkt = head_new;
    end else begin
      tkt = '0;
    end

    // a served ticket is never zero, so one flag per counter is enough
    served_next = served;
    if (next_ok) begin
      served_next[c_idx] = 1'b1;
    end

    count = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (map[i*MAP_FIELD_BITS +: MAP_FIELD_BITS] == queue) begin
        count = count + 5'd1;
      end
    end

    first_idle = NS5;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!served_next[i]) begin
        first_idle = 5'(i);
      end
    end

    if (is_push && full) begin
      rsp_next.status = ST_FULL;
    end else if (is_next && empty) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.status = ST_OK;
    end
    rsp_next.ticket = 16'({16'h0000, tkt});
    rsp_next.selected_queue = queue;
    rsp_next.queue_head = slot_ok ? 16'({16'h0000, head_new}) : '0;
    rsp_next.tickets_waiting = slot_ok ? 16'({16'h0000, waiting}) : '0;
    rsp_next.counters_on_queue = count;
    rsp_next.first_idle_counter = first_idle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        heads[i] <= '0;
        tails[i] <= '0;
      end
      served <= '0;
      done <= 1'b0;
    end else begin
      if (req.valid && push_ok) begin
        tails[q_idx] <= tail_new;
      end
      if (req.valid && next_ok) begin
        heads[q_idx] <= head_new;
        served <= served_next;
      end
      done <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== rtl/core/multi_queue_ticket_dispenser.sv =====
// ----------------------------------------------------------------------------
// multi_queue_ticket_dispenser
// Take-a-number dispenser: per-queue head/tail counters, counter-to-queue
// map, one result per command.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   start, busy               command, id
//  result    done (one-cycle strobe)   status, ticket, selected_queue,
//                                      queue_head, tickets_waiting,
//                                      counters_on_queue, first_idle_counter
//  config    APB psel/penable/pwrite   paddr, pwdata, prdata (map at 0x0)
//
//  one command per cycle; the result strobe follows acceptance through the
//  input register, then the state update and result register in one pass
//  busy is high during reset and in the cycle after it, low otherwise
//  state changes land before the next command reads it, so no stall between
//  commands; results cannot be held off and each shows for one cycle
// ----------------------------------------------------------------------------
module multi_queue_ticket_dispenser
  import mqtd_pkg::*;
#(
  parameter int NUM_SLOTS   = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [3:0]  id,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] ticket,
  output logic [3:0]  selected_queue,
  output logic [15:0] queue_head,
  output logic [15:0] tickets_waiting,
  output logic [4:0]  counters_on_queue,
  output logic [4:0]  first_idle_counter,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  req_t        req;
  rsp_t        rsp;
  logic [63:0] map;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      req.valid <= 1'b0;
    end else begin
      busy <= 1'b0;
      req.valid <= start && !busy;
    end
    req.command <= command;
    req.id <= id;
  end

  mqtd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .map     (map)
  );

  mqtd_exec #(
    .NUM_SLOTS   (NUM_SLOTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_exec (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .map  (map),
    .done (done),
    .rsp  (rsp)
  );

  assign status             = rsp.status;
  assign ticket             = rsp.ticket;
  assign selected_queue     = rsp.selected_queue;
  assign queue_head         = rsp.queue_head;
  assign tickets_waiting    = rsp.tickets_waiting;
  assign counters_on_queue  = rsp.counters_on_queue;
  assign first_idle_counter = rsp.first_idle_counter;

  // every accepted item yields a result strobe
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req.valid))
    else $error("result strobe without an item");

  a_fail_no_ticket: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL || status == ST_EMPTY)) |-> (ticket == 16'd0))
    else $error("ticket issued on a failed command");

  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (counters_on_queue <= 5'(NUM_SLOTS) && first_idle_counter <= 5'(NUM_SLOTS)))
    else $error("counter figures out of range");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-queue ticket dispenser. Commands go in
// through start/busy, the counter-to-queue map is set over APB, and every
// result strobe is checked field by field against an in-bench copy of the
// head, tail and served-ticket state.
// ----------------------------------------------------------------------------
module tb_top
  import mqtd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS      = 16;
  localparam int          TKT_MAX    = 65535;
  localparam logic [3:0]  MAP_ADDR   = {REG_MAP, 3'b000};
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // tracks dispenser state and the results still owed by the block
  class dispenser_predictor;
    bit [63:0]   queue_map;
    bit [15:0]   heads[SLOTS];
    bit [15:0]   tails[SLOTS];
    bit [15:0]   served[SLOTS];
    rsp_t        expected_results[$];
    int unsigned mismatches;

    function void load_map(bit [63:0] value);
      queue_map = value;
    endfunction

    function void report_mismatch(string what, longint unsigned exp_v,
                                  longint unsigned act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
                 exp_v, act_v);
    endfunction

    function void check_value(string what, longint unsigned exp_v,
                              longint unsigned act_v);
      if (exp_v != act_v) report_mismatch(what, exp_v, act_v);
    endfunction

    function void accept_command(logic [1:0] cmd, logic [3:0] ident);
      rsp_t r;
      int   q;
      int   n;
      r = '0;
      q = (cmd == CMD_NEXT || cmd == CMD_QRY_CNT) ? int'(queue_map[ident*4 +: 4])
                                                  : int'(ident);
      r.selected_queue = q[3:0];
      if (q < SLOTS && ident < SLOTS) begin
        case (cmd)
          CMD_PUSH: begin
            if (tails[q] == TKT_MAX) begin
              r.status = ST_FULL;
            end else begin
              tails[q]++;
              r.ticket = tails[q];
            end
          end
          CMD_NEXT: begin
            if (heads[q] >= tails[q]) begin
              r.status = ST_EMPTY;
            end else begin
              heads[q]++;
              served[ident] = heads[q];
              r.ticket = heads[q];
            end
          end
          default: ;
        endcase
        r.queue_head      = heads[q];
        r.tickets_waiting = tails[q] - heads[q];
      end
      n = 0;
      for (int i = 0; i < SLOTS; i++)
        if (queue_map[i*4 +: 4] == q[3:0]) n++;
      r.counters_on_queue = n[4:0];
      r.first_idle_counter = 5'(SLOTS);
      for (int i = SLOTS - 1; i >= 0; i--)
        if (served[i] == 0) r.first_idle_counter = i[4:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(rsp_t act);
      rsp_t exp_r;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result strobe", 0, 1);
        return;
      end
      exp_r = expected_results.pop_front();
      check_value("status", exp_r.status, act.status);
      check_value("ticket", exp_r.ticket, act.ticket);
      check_value("selected_queue", exp_r.selected_queue, act.selected_queue);
      check_value("queue_head", exp_r.queue_head, act.queue_head);
      check_value("tickets_waiting", exp_r.tickets_waiting, act.tickets_waiting);
      check_value("counters_on_queue", exp_r.counters_on_queue, act.counters_on_queue);
      check_value("first_idle_counter", exp_r.first_idle_counter,
                  act.first_idle_counter);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [3:0]  id;
  logic        done;
  logic [1:0]  status;
  logic [15:0] ticket;
  logic [3:0]  selected_queue;
  logic [15:0] queue_head;
  logic [15:0] tickets_waiting;
  logic [4:0]  counters_on_queue;
  logic [4:0]  first_idle_counter;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  dispenser_predictor tally = new();
  int unsigned        cycle_count = 0;

  multi_queue_ticket_dispenser u_top (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .command            (command),
    .id                 (id),
    .done               (done),
    .status             (status),
    .ticket             (ticket),
    .selected_queue     (selected_queue),
    .queue_head         (queue_head),
    .tickets_waiting    (tickets_waiting),
    .counters_on_queue  (counters_on_queue),
    .first_idle_counter (first_idle_counter),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // results cannot be held off, so take every strobe as it comes
  always @(posedge clk) begin
    if (!rst && done)
      tally.check_result('{status, ticket, selected_queue, queue_head,
                           tickets_waiting, counters_on_queue, first_idle_counter});
  end

  // called at a rising edge, returns at the edge that accepts the item
  task automatic send_command(input logic [1:0] cmd, input logic [3:0] ident);
    start   <= 1'b1;
    command <= cmd;
    id      <= ident;
    @(posedge clk);
    while (busy) @(posedge clk);
    tally.accept_command(cmd, ident);
  endtask

  task automatic pause(input int cycles);
    start   <= 1'b0;
    command <= 2'($urandom);
    id      <= 4'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tally.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_map(input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAP_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tally.load_map(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    pwdata  <= '0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tally.check_value("map readback", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int items, input bit with_gaps);
    int          pick;
    logic [1:0]  cmd;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      cmd = CMD_PUSH;
      else if (pick < 75) cmd = CMD_NEXT;
      else if (pick < 88) cmd = CMD_QRY_CNT;
      else                cmd = CMD_QRY_QUEUE;
      send_command(cmd, 4'($urandom));
      // a gap follows about one item in four; otherwise items go back to back
      if (with_gaps && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 14));
    end
  endtask

  initial begin
    rst     <= 1'b1;
    start   <= 1'b0;
    command <= CMD_PUSH;
    id      <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // counter i serves queue i
    write_map(64'hFEDC_BA98_7654_3210);

    send_command(CMD_QRY_QUEUE, 4'd0);
    send_command(CMD_NEXT, 4'd0);        // nothing waiting
    send_command(CMD_PUSH, 4'd0);
    send_command(CMD_PUSH, 4'd0);
    send_command(CMD_PUSH, 4'd15);
    send_command(CMD_QRY_QUEUE, 4'd15);
    send_command(CMD_NEXT, 4'd0);
    pause(3);
    send_command(CMD_NEXT, 4'd15);
    send_command(CMD_NEXT, 4'd15);       // queue 15 already drained
    send_command(CMD_QRY_CNT, 4'd0);
    send_command(CMD_QRY_CNT, 4'd15);
    send_command(CMD_NEXT, 4'd0);
    send_command(CMD_NEXT, 4'd0);
    send_command(CMD_QRY_QUEUE, 4'd7);
    drain();

    // every counter on queue 15; a run of tickets, then each counter calls one
    write_map('1);
    for (int n = 0; n < 40; n++)
      send_command(CMD_PUSH, 4'd15);
    for (int c = 0; c < SLOTS; c++)
      send_command(CMD_NEXT, 4'(c));     // every counter has now served
    send_command(CMD_QRY_QUEUE, 4'd15);
    send_command(CMD_QRY_CNT, 4'd9);
    drain();

    write_map('0);
    run_random(400, 1'b1);
    drain();
    write_map({$urandom, $urandom});
    run_random(350, 1'b1);
    drain();
    write_map({$urandom, $urandom});
    run_random(300, 1'b1);
    drain();
    write_map({$urandom, $urandom});
    run_random(200, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (tally.mismatches == 0 && tally.expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
